>>> rtl/nalsplit_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nalsplit_pkg
// Types and constants shared by the Annex B NAL unit splitter.
// ============================================================================
package nalsplit_pkg;

    // Zeros held back inside a unit before they spill out as data.
    localparam int HOLD_ZEROS = 16;
    localparam int HOLD_LIMIT_INT = (HOLD_ZEROS > 16) ? 16 : HOLD_ZEROS;
    localparam logic [4:0] HOLD_LIMIT = 5'(HOLD_LIMIT_INT);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    // Number of bytes in the 00 00 01 prefix.
    localparam logic [1:0] PREFIX_LEN = 2'd3;
    localparam logic [1:0] LEAD_MAX   = 2'd3;
    localparam logic [1:0] LEAD_MIN   = 2'd2;
    localparam logic [4:0] HELD_MIN   = 5'd2;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_EOS  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_END      = 2'd1,
        KIND_NO_START = 2'd2,
        KIND_CUT      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_UNIT   = 2'd1,
        PH_IGNORE = 2'd2
    } t_phase;

    typedef enum logic [0:0] {
        CFG_END_HAS_SC = 1'b0,
        CFG_EMIT_SC    = 1'b1
    } t_cfg_idx;

    // Compact description of the results one input item causes: an optional
    // 00 00 01 prefix, a run of zero bytes, an optional data byte and an
    // optional closing result, in that order.
    typedef struct packed {
        logic       pre;
        logic [4:0] zeros;
        logic       byte_en;
        logic [7:0] byte_val;
        logic       term_en;
        t_kind      term_kind;
    } t_desc;

endpackage

>>> rtl/nalsplit_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// nalsplit_in_if
// Input channel of the splitter: stream bytes and end-of-stream markers.
// ============================================================================
interface nalsplit_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

>>> rtl/nalsplit_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// nalsplit_out_if
// Result channel of the splitter: unit bytes and unit status results.
// ============================================================================
interface nalsplit_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] unit_byte;
    logic       last;

    modport source (output valid, output kind, output unit_byte, output last, input ready);
    modport sink   (input valid, input kind, input unit_byte, input last, output ready);
endinterface

>>> rtl/nalsplit_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// nalsplit_parser
// Start code parser: holds the stream state and describes the results of
// each accepted item.
// ============================================================================
module nalsplit_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_operation,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_has_sc,
    input  logic                  i_emit_sc,
    output nalsplit_pkg::t_desc   o_desc
);
    import nalsplit_pkg::*;

    t_phase     r_phase,  n_phase;
    logic [1:0] r_lead,   n_lead;
    logic [4:0] r_held,   n_held;
    logic       r_has,    n_has;
    t_desc      desc;
    logic [4:0] close_zeros;

    // A unit closed before any data byte still keeps one zero if any was held.
    assign close_zeros = (!r_has && (r_held != 5'd0)) ? 5'd1 : 5'd0;

    always_comb begin
        n_phase        = r_phase;
        n_lead         = r_lead;
        n_held         = r_held;
        n_has          = r_has;
        desc           = '0;
        desc.byte_val  = i_data_byte;
        desc.term_kind = KIND_DATA;

        if (i_operation == OP_EOS) begin
            if (r_phase == PH_UNIT) begin
                desc.term_en = 1'b1;
                if (i_end_has_sc) begin
                    desc.zeros     = close_zeros;
                    desc.term_kind = KIND_END;
                end else begin
                    desc.zeros     = r_held;
                    desc.term_kind = KIND_CUT;
                end
            end
            n_phase = PH_SEEK;
            n_lead  = 2'd0;
            n_held  = 5'd0;
            n_has   = 1'b0;
        end else begin
            case (r_phase)
                PH_SEEK: begin
                    if (i_data_byte == BYTE_ZERO) begin
                        if (r_lead < LEAD_MAX) begin
                            n_lead = r_lead + 2'd1;
                        end
                    end else if (i_data_byte == BYTE_ONE && r_lead >= LEAD_MIN) begin
                        n_phase = PH_UNIT;
                        n_lead  = 2'd0;
                        n_held  = 5'd0;
                        n_has   = 1'b0;
                    end else begin
                        desc.term_en   = 1'b1;
                        desc.term_kind = KIND_NO_START;
                        n_phase        = PH_IGNORE;
                        n_lead         = 2'd0;
                    end
                end
                PH_UNIT: begin
                    if (i_data_byte == BYTE_ZERO) begin
                        if (r_held < HOLD_LIMIT) begin
                            n_held = r_held + 5'd1;
                        end else begin
                            desc.zeros = 5'd1;
                            n_has      = 1'b1;
                        end
                    end else if (i_data_byte == BYTE_ONE && r_held >= HELD_MIN) begin
                        desc.zeros     = close_zeros;
                        desc.term_en   = 1'b1;
                        desc.term_kind = KIND_END;
                        n_held         = 5'd0;
                        n_has          = 1'b0;
                    end else begin
                        desc.zeros   = r_held;
                        desc.byte_en = 1'b1;
                        n_held       = 5'd0;
                        n_has        = 1'b1;
                    end
                end
                default: begin
                    // Bytes after a missing start code are dropped.
                end
            endcase
        end

        // The prefix goes ahead of the first data byte of a unit.
        desc.pre = i_emit_sc && !r_has && ((desc.zeros != 5'd0) || desc.byte_en);
    end

    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_lead  <= 2'd0;
            r_held  <= 5'd0;
            r_has   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_lead  <= n_lead;
            r_held  <= n_held;
            r_has   <= n_has;
        end
    end

endmodule

>>> rtl/annexb_nal_unit_splitter_core.sv
`timescale 1ns / 1ps
// ============================================================================
// annexb_nal_unit_splitter_core
// Splits an H.264 Annex B byte stream into NAL unit bytes and unit results.
// ============================================================================
// An accepted item is parsed in the cycle of its transfer and leaves a short
// description of its results in a sequencer register; the sequencer hands
// one result per cycle to the output register while the output does not
// stall. Items that cause no result or one result do not hold the input, so
// they stream at one per clock unless the output stalls. An item that causes
// more results (up to 20 when a full zero hold is flushed behind a start code
// prefix) holds the input, as the one output register takes them in turn.
// The input is taken again in the cycle the last result of the previous item
// moves to the output register, while that result may still wait to be taken.
module annexb_nal_unit_splitter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic      i_cfg_wdata,
    nalsplit_in_if.sink    i_byte_ch,
    nalsplit_out_if.source o_result_ch
);
    import nalsplit_pkg::*;

    logic       r_end_has_sc;
    logic       r_emit_sc;

    t_desc      desc;
    logic       accept;

    logic [1:0] r_pre_left,  n_pre_left;
    logic [4:0] r_zero_left, n_zero_left;
    logic       r_byte_pend, n_byte_pend;
    logic [7:0] r_byte_val;
    logic       r_term_pend, n_term_pend;
    t_kind      r_term_kind;

    t_kind      e_kind;
    logic [7:0] e_byte;
    logic       e_last;
    logic       busy;
    logic       out_free;
    logic       step;

    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_has_sc <= 1'b0;
            r_emit_sc    <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_END_HAS_SC: r_end_has_sc <= i_cfg_wdata;
                CFG_EMIT_SC:    r_emit_sc    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    nalsplit_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_byte_ch.operation),
        .i_data_byte  (i_byte_ch.data_byte),
        .i_end_has_sc (r_end_has_sc),
        .i_emit_sc    (r_emit_sc),
        .o_desc       (desc)
    );

    // Pick the next result in order: prefix, held zeros, data byte, status.
    always_comb begin
        n_pre_left  = r_pre_left;
        n_zero_left = r_zero_left;
        n_byte_pend = r_byte_pend;
        n_term_pend = r_term_pend;
        e_kind      = KIND_DATA;
        e_byte      = BYTE_ZERO;
        if (r_pre_left != 2'd0) begin
            e_byte     = (r_pre_left == 2'd1) ? BYTE_ONE : BYTE_ZERO;
            n_pre_left = r_pre_left - 2'd1;
        end else if (r_zero_left != 5'd0) begin
            n_zero_left = r_zero_left - 5'd1;
        end else if (r_byte_pend) begin
            e_byte      = r_byte_val;
            n_byte_pend = 1'b0;
        end else begin
            e_kind      = r_term_kind;
            n_term_pend = 1'b0;
        end
    end

    assign busy     = (r_pre_left != 2'd0) || (r_zero_left != 5'd0) || r_byte_pend
                      || r_term_pend;
    assign e_last   = !((n_pre_left != 2'd0) || (n_zero_left != 5'd0) || n_byte_pend
                      || n_term_pend);
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign step     = busy && out_free;

    assign i_byte_ch.ready = !busy || (step && e_last);
    assign accept          = i_byte_ch.valid && i_byte_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_left  <= 2'd0;
            r_zero_left <= 5'd0;
            r_byte_pend <= 1'b0;
            r_term_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pre_left  <= desc.pre ? PREFIX_LEN : 2'd0;
                r_zero_left <= desc.zeros;
                r_byte_pend <= desc.byte_en;
                r_term_pend <= desc.term_en;
            end else if (step) begin
                r_pre_left  <= n_pre_left;
                r_zero_left <= n_zero_left;
                r_byte_pend <= n_byte_pend;
                r_term_pend <= n_term_pend;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_val  <= desc.byte_val;
            r_term_kind <= desc.term_kind;
        end
        if (step) begin
            r_out_kind <= e_kind;
            r_out_byte <= (e_kind == KIND_DATA) ? e_byte : BYTE_ZERO;
            r_out_last <= e_last;
        end
    end

    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.kind      = r_out_kind;
    assign o_result_ch.unit_byte = r_out_byte;
    assign o_result_ch.last      = r_out_last;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the Annex B NAL unit splitter core.
// ============================================================================
// Stream items come from a queue that the stimulus process fills, phase by
// phase. Each phase uses its own register setting. A clocked driver offers
// the items with random gaps. A clocked monitor takes the results with random
// stalls. Every accepted item runs through a local model of the splitter, and
// the results it predicts are compared field by field with what comes out.
// The directed part covers missing start codes, empty units, zero runs past
// the hold limit and cut-off units. Random well-formed streams follow, mixed
// with broken ones.
module testbench;
    import nalsplit_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned PHASE_ITEMS   = 36;
    localparam int unsigned RANDOM_PHASES = 6;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_stream_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] unit_byte;
        logic       last;
    } t_split_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_wdata;

    nalsplit_in_if  byte_ch ();
    nalsplit_out_if result_ch ();

    annexb_nal_unit_splitter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    always #1 i_clk = ~i_clk;

    t_stream_item  stream_items[$];
    t_split_result expected_results[$];
    t_split_result item_results[$];

    // Local copy of the splitter state and its registers.
    t_phase     sp_phase;
    logic [1:0] sp_lead;
    logic [4:0] sp_held;
    logic       sp_has;
    logic       cfg_end_sc;
    logic       cfg_emit_sc;

    bit          src_idle_en;
    bit          snk_idle_en;
    int unsigned hold_reqs;
    int unsigned hold_done;
    int unsigned long_hold_left;
    int unsigned src_gap;
    int unsigned snk_wait;

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned useful_items;
    int unsigned items_accepted;
    int unsigned results_checked;
    int unsigned units_ended;
    int unsigned units_cut;
    int unsigned start_errors;
    int unsigned settings_used;

    // ------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------
    function automatic void add_result(t_kind k, logic [7:0] b);
        t_split_result r;
        r.kind      = k;
        r.unit_byte = (k == KIND_DATA) ? b : 8'h00;
        r.last      = 1'b0;
        item_results.push_back(r);
    endfunction

    // The first data byte of a unit may carry the 00 00 01 prefix in front.
    function automatic void add_unit_byte(logic [7:0] b);
        if (!sp_has && cfg_emit_sc) begin
            add_result(KIND_DATA, BYTE_ZERO);
            add_result(KIND_DATA, BYTE_ZERO);
            add_result(KIND_DATA, BYTE_ONE);
        end
        sp_has = 1'b1;
        add_result(KIND_DATA, b);
    endfunction

    function automatic void flush_held_zeros();
        while (sp_held != 5'd0) begin
            add_unit_byte(BYTE_ZERO);
            sp_held = sp_held - 5'd1;
        end
    endfunction

    // A unit never closes empty when zeros were held: one of them is kept.
    function automatic void close_current_unit();
        if (!sp_has && sp_held != 5'd0)
            add_unit_byte(BYTE_ZERO);
        sp_held = 5'd0;
        sp_has  = 1'b0;
        add_result(KIND_END, BYTE_ZERO);
    endfunction

    function automatic void split_predict(t_op op, logic [7:0] b);
        t_split_result r;
        item_results.delete();
        if (op == OP_EOS) begin
            if (sp_phase == PH_UNIT) begin
                if (cfg_end_sc) begin
                    close_current_unit();
                end else begin
                    flush_held_zeros();
                    add_result(KIND_CUT, BYTE_ZERO);
                end
            end
            sp_phase = PH_SEEK;
            sp_lead  = 2'd0;
            sp_held  = 5'd0;
            sp_has   = 1'b0;
        end else begin
            case (sp_phase)
                PH_SEEK: begin
                    if (b == BYTE_ZERO) begin
                        if (sp_lead < LEAD_MAX)
                            sp_lead = sp_lead + 2'd1;
                    end else if (b == BYTE_ONE && sp_lead >= LEAD_MIN) begin
                        sp_phase = PH_UNIT;
                        sp_lead  = 2'd0;
                        sp_held  = 5'd0;
                        sp_has   = 1'b0;
                    end else begin
                        add_result(KIND_NO_START, BYTE_ZERO);
                        sp_phase = PH_IGNORE;
                        sp_lead  = 2'd0;
                    end
                end
                PH_UNIT: begin
                    if (b == BYTE_ZERO) begin
                        if (sp_held < HOLD_LIMIT)
                            sp_held = sp_held + 5'd1;
                        else
                            add_unit_byte(BYTE_ZERO);
                    end else if (b == BYTE_ONE && sp_held >= HELD_MIN) begin
                        close_current_unit();
                    end else begin
                        flush_held_zeros();
                        add_unit_byte(b);
                    end
                end
                default: begin
                end
            endcase
        end
        foreach (item_results[i]) begin
            r = item_results[i];
            r.last = (i == item_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stream_item nxt;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                split_predict(t_op'(byte_ch.operation), byte_ch.data_byte);
                items_accepted++;
            end
            if (byte_ch.valid && !byte_ch.ready) begin
                // Offer stays up until the transfer happens.
            end else if (src_gap != 0) begin
                src_gap--;
                byte_ch.valid <= 1'b0;
            end else if (stream_items.size() != 0) begin
                nxt = stream_items.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.operation <= nxt.op;
                byte_ch.data_byte <= nxt.data;
                src_gap = src_idle_en ? $urandom_range(0, 6) : 0;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_split_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            snk_wait = 0;
            long_hold_left = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d, unit_byte 0x%02h, last %0b",
                           result_ch.kind, result_ch.unit_byte, result_ch.last);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, result_ch.kind);
                        fail_count++;
                    end
                    if (result_ch.unit_byte !== want.unit_byte) begin
                        $error("unit_byte: expected 0x%02h, got 0x%02h",
                               want.unit_byte, result_ch.unit_byte);
                        fail_count++;
                    end
                    if (result_ch.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, result_ch.last);
                        fail_count++;
                    end
                    case (want.kind)
                        KIND_END:      units_ended++;
                        KIND_CUT:      units_cut++;
                        KIND_NO_START: start_errors++;
                        default: begin
                        end
                    endcase
                end
                snk_wait = snk_idle_en ? $urandom_range(0, 6) : 0;
            end
            if (long_hold_left != 0) begin
                long_hold_left--;
                result_ch.ready <= 1'b0;
            end else if (hold_reqs != hold_done) begin
                hold_done++;
                long_hold_left = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end else if (snk_wait != 0) begin
                snk_wait--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) cycle_count++;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(t_op op, logic [7:0] b, bit counted = 1'b1);
        t_stream_item it;
        it.op   = op;
        it.data = b;
        stream_items.push_back(it);
        if (counted)
            useful_items++;
    endtask

    task automatic push_bytes(int unsigned count, logic [7:0] b);
        repeat (count) push_item(OP_BYTE, b);
    endtask

    task automatic push_start_code(int unsigned zeros);
        push_bytes(zeros, BYTE_ZERO);
        push_item(OP_BYTE, BYTE_ONE);
    endtask

    function automatic logic [7:0] unit_content_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return BYTE_ZERO;
        else if (r == 4)
            return BYTE_ONE;
        else if (r == 5)
            return 8'h03;
        else if (r == 6)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One stretch of stream that always ends in end of stream, so the next
    // one starts from the seeking state.
    task automatic gen_chunk();
        int unsigned r;
        int unsigned units;
        int unsigned len;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                push_bytes($urandom_range(0, 3), BYTE_ZERO);
                push_item(OP_BYTE, 8'($urandom_range(2, 255)));
            end else begin
                push_bytes($urandom_range(0, 1), BYTE_ZERO);
                push_item(OP_BYTE, BYTE_ONE);
            end
            repeat ($urandom_range(0, 3))
                push_item(OP_BYTE, unit_content_byte(), 1'b0);
            push_item(OP_EOS, 8'($urandom_range(0, 255)));
        end else if (r == 1) begin
            push_bytes($urandom_range(0, 4), BYTE_ZERO);
            push_item(OP_EOS, 8'($urandom_range(0, 255)));
        end else begin
            push_start_code($urandom_range(2, 4));
            units = $urandom_range(1, 4);
            for (int unsigned u = 0; u < units; u++) begin
                if (u != 0)
                    push_start_code($urandom_range(2, 3));
                len = $urandom_range(1, 12);
                repeat (len) begin
                    if ($urandom_range(0, 15) == 0)
                        push_bytes($urandom_range(14, 20), BYTE_ZERO);
                    else
                        push_item(OP_BYTE, unit_content_byte());
                end
            end
            if ($urandom_range(0, 5) == 0)
                push_start_code($urandom_range(2, 3));
            else
                push_bytes($urandom_range(0, 3), BYTE_ZERO);
            push_item(OP_EOS, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_config(logic end_sc, logic emit_sc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_END_HAS_SC;
        i_cfg_wdata <= end_sc;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_EMIT_SC;
        i_cfg_wdata <= emit_sc;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_end_sc  = end_sc;
        cfg_emit_sc = emit_sc;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (stream_items.size() != 0 || byte_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned start_count;
        logic        end_sc;
        logic        emit_sc;

        byte_ch.valid     = 1'b0;
        byte_ch.operation = OP_BYTE;
        byte_ch.data_byte = 8'h00;
        result_ch.ready   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_END_HAS_SC;
        i_cfg_wdata = 1'b0;
        sp_phase    = PH_SEEK;
        sp_lead     = 2'd0;
        sp_held     = 5'd0;
        sp_has      = 1'b0;
        cfg_end_sc  = 1'b0;
        cfg_emit_sc = 1'b1;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Cut-off units at end of stream, prefix on.
        write_config(1'b0, 1'b1);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_EOS, 8'h00);
        push_start_code(4);
        push_item(OP_BYTE, BYTE_ZERO);
        push_item(OP_BYTE, BYTE_ONE);
        push_item(OP_BYTE, 8'hFF);
        push_start_code(2);
        push_start_code(2);
        push_start_code(17);
        push_item(OP_BYTE, 8'h80);
        push_bytes(2, BYTE_ZERO);
        push_item(OP_EOS, 8'hFF);
        wait_idle();

        // Normal close at end of stream, prefix off.
        write_config(1'b1, 1'b0);
        push_start_code(2);
        push_item(OP_EOS, 8'h7F);
        push_item(OP_EOS, 8'h00);
        push_start_code(3);
        push_item(OP_BYTE, 8'h7F);
        push_bytes(3, BYTE_ZERO);
        push_item(OP_EOS, 8'h00);
        wait_idle();

        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin end_sc = 1'b1; emit_sc = 1'b1; end
                1: begin end_sc = 1'b0; emit_sc = 1'b0; end
                2: begin end_sc = 1'b1; emit_sc = 1'b0; end
                3: begin end_sc = 1'b0; emit_sc = 1'b1; end
                default: begin
                    end_sc  = 1'($urandom_range(0, 1));
                    emit_sc = 1'($urandom_range(0, 1));
                end
            endcase
            // One phase runs with no idling at all, one with idling on both sides.
            if (p == 1) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end else if (p == 2) begin
                src_idle_en = 1'b1;
                snk_idle_en = 1'b1;
            end else begin
                src_idle_en = 1'($urandom_range(0, 1));
                snk_idle_en = 1'($urandom_range(0, 1));
            end
            write_config(end_sc, emit_sc);
            start_count = useful_items;
            while (useful_items - start_count < PHASE_ITEMS)
                gen_chunk();
            // The result side stops for a long stretch while the driver keeps
            // offering, so the core backs up and stalls its input.
            if (p == 2)
                hold_reqs++;
            wait_idle();
        end

        $display("Run covered %0d stream items over %0d register settings, %0d results checked.",
                 items_accepted, settings_used, results_checked);
        $display("Units closed %0d, units cut off %0d, missing start codes %0d.",
                 units_ended, units_cut, start_errors);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
